// ===== hdl/cid_pkg.sv =====
// Shared constants and types of the current imbalance detector.
package cid_pkg;

   localparam int DATA_W    = 32;
   localparam int RATE_W    = 7;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = $clog2(DATA_W);

   // input size limits that pick the multiply/divide order
   localparam logic [DATA_W-1:0] RISK10_LIMIT  = 32'h028F_5C28;
   localparam logic [DATA_W-1:0] RISK100_LIMIT = 32'h1999_9999;

   localparam logic [RATE_W-1:0]  FULL_RATE = 7'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMBALANCE_PERCENT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LEVEL_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LEVEL_B     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_GATE        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DENOMINATOR_MODE  = 3'd4;

   // register reset values
   localparam logic [RATE_W-1:0]  RST_IMBALANCE_PERCENT = 7'd10;
   localparam logic [COUNT_W-1:0] RST_COUNT_GATE        = 8'd3;

   // denominator modes; any other code picks channel B
   localparam logic [1:0] DEN_ACTIVE = 2'd0;
   localparam logic [1:0] DEN_CHAN_A = 2'd1;

   // scaling order of the percent computation
   localparam logic [1:0] SCALE_X100 = 2'd0;   // diff*100/den
   localparam logic [1:0] SCALE_X10  = 2'd1;   // (diff*10/den)*10
   localparam logic [1:0] SCALE_X1   = 2'd2;   // (diff/den)*100

   typedef struct packed {
      logic update;   // commit this item's win decision
      logic hit;      // rate reached the threshold
      logic a_wins;   // channel A strictly larger
   } cid_win_cmd_type;

   typedef struct packed {
      logic channel;    // active channel before the update, 0 A, 1 B
      logic switched;   // this decision toggles the active channel
   } cid_win_stat_type;

endpackage

// ===== hdl/cid_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
module cid_divider
   import cid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic [DATA_W-1:0] quotient,
   output logic              done
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in  = {quo_ff[DATA_W-2:0], fits};
         step_in = step_ff + 1'b1;
         // last quotient bit
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hdl/cid_win_tracker.sv =====
// Active channel and consecutive win counters with switch decision.
module cid_win_tracker
   import cid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] count_gate,
   input  cid_win_cmd_type    cmd,
   output cid_win_stat_type   stat
);

   logic               channel_ff, channel_in;
   logic [COUNT_W-1:0] count_a_ff, count_a_in;
   logic [COUNT_W-1:0] count_b_ff, count_b_in;
   logic [COUNT_W-1:0] bump_a, bump_b;
   logic               a_side, b_side, switched;

   assign bump_a = (count_a_ff == COUNT_MAX) ? COUNT_MAX : count_a_ff + 1'b1;
   assign bump_b = (count_b_ff == COUNT_MAX) ? COUNT_MAX : count_b_ff + 1'b1;

   // a win only counts for the inactive channel; ties go to B
   assign a_side   = cmd.hit &&  cmd.a_wins &&  channel_ff;
   assign b_side   = cmd.hit && !cmd.a_wins && !channel_ff;
   assign switched = (a_side && (bump_a > count_gate)) ||
                     (b_side && (bump_b > count_gate));

   always_comb begin
      channel_in = channel_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (cmd.update) begin
         if (switched) begin
            channel_in = ~channel_ff;
            count_a_in = '0;
            count_b_in = '0;
         end else if (a_side) begin
            count_a_in = bump_a;
            count_b_in = '0;
         end else if (b_side) begin
            count_b_in = bump_b;
            count_a_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= 1'b0;
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         channel_ff <= channel_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   assign stat.channel  = channel_ff;
   assign stat.switched = switched;

endmodule

// ===== hdl/current_imbalance_detector_unit.sv =====
// An input transfer starts DIFF, SCALE, DIV (the 32-step serial divider), RATE and DONE.
// One item at a time: req_tready is high only while the sequencer is idle.
// A zero denominator skips the divider: SCALE goes straight to RATE.
// The result register lets the next item in while a result still waits.
// Synchronous active-high reset clears sequencer, channel, counters and valid, and resets CSRs.
module current_imbalance_detector_unit
   import cid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // current_a[31:0], current_b[63:32]
   input  logic                 req_tuser,   // normal_mode[0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // imbalance_rate[6:0], imbalance_flag[7],
                                             // channel_switched[8], active_channel[9],
                                             // cf_open_request[10], zero[15:11]
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIFF  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_RATE  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // configuration
   logic [RATE_W-1:0]  percent_ff;
   logic [DATA_W-1:0]  start_a_ff, start_b_ff;
   logic [COUNT_W-1:0] gate_ff;
   logic [1:0]         den_mode_ff;

   logic [2:0]         state_ff, state_in;
   logic [DATA_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic               normal_ff, normal_in;
   logic [DATA_W-1:0]  diff_ff, diff_in;
   logic [DATA_W-1:0]  den_ff, den_in;
   logic [1:0]         scale_ff, scale_in;
   logic               a_wins_ff, a_wins_in;
   logic               below_ff, below_in;
   logic               den_zero_ff, den_zero_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]        rsp_tdata_ff, rsp_tdata_in;

   logic               accept;
   logic               div_start, div_done;
   logic [DATA_W-1:0]  numerator, quotient;
   logic [RATE_W-1:0]  times10;
   logic               out_free, hit, flag;
   cid_win_cmd_type    win_cmd;
   cid_win_stat_type   win_stat;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         percent_ff  <= RST_IMBALANCE_PERCENT;
         start_a_ff  <= '0;
         start_b_ff  <= '0;
         gate_ff     <= RST_COUNT_GATE;
         den_mode_ff <= DEN_ACTIVE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMBALANCE_PERCENT: percent_ff  <= csr_wdata[RATE_W-1:0];
            CSR_START_LEVEL_A:     start_a_ff  <= csr_wdata;
            CSR_START_LEVEL_B:     start_b_ff  <= csr_wdata;
            CSR_COUNT_GATE:        gate_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_DENOMINATOR_MODE:  den_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // numerator by shift and add; the scaling order keeps it within 32 bits
   always_comb begin
      case (scale_ff)
         SCALE_X100: numerator = {diff_ff[25:0], 6'b0} + {diff_ff[26:0], 5'b0} +
                                 {diff_ff[29:0], 2'b0};
         SCALE_X10:  numerator = {diff_ff[28:0], 3'b0} + {diff_ff[30:0], 1'b0};
         default:    numerator = diff_ff;
      endcase
   end

   assign times10 = {quotient[3:0], 3'b0} + {2'b0, quotient[3:0], 1'b0};
   assign hit     = (rate_ff >= percent_ff);
   assign flag    = hit && !below_ff;

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      normal_in     = normal_ff;
      diff_in       = diff_ff;
      den_in        = den_ff;
      scale_in      = scale_ff;
      a_wins_in     = a_wins_ff;
      below_in      = below_ff;
      den_zero_in   = den_zero_ff;
      rate_in       = rate_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      div_start     = 1'b0;
      win_cmd       = '{update: 1'b0, hit: hit, a_wins: a_wins_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in      = req_tdata[31:0];
               b_in      = req_tdata[63:32];
               normal_in = req_tuser;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            a_wins_in = (a_ff > b_ff);
            diff_in   = (a_ff > b_ff) ? a_ff - b_ff : b_ff - a_ff;
            below_in  = (a_ff < start_a_ff) && (b_ff < start_b_ff);
            if (den_mode_ff == DEN_ACTIVE) begin
               den_in = win_stat.channel ? b_ff : a_ff;
            end else if (den_mode_ff == DEN_CHAN_A) begin
               den_in = a_ff;
            end else begin
               den_in = b_ff;
            end
            if (a_ff >= RISK100_LIMIT || b_ff >= RISK100_LIMIT) begin
               scale_in = SCALE_X1;
            end else if (a_ff >= RISK10_LIMIT || b_ff >= RISK10_LIMIT) begin
               scale_in = SCALE_X10;
            end else begin
               scale_in = SCALE_X100;
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            den_zero_in = (den_ff == '0);
            // skip the divider on a zero denominator
            if (den_ff == '0) begin
               state_in = ST_RATE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            if (den_zero_ff) begin
               rate_in = FULL_RATE;
            end else begin
               case (scale_ff)
                  SCALE_X100: rate_in = (quotient >= DATA_W'(FULL_RATE)) ? FULL_RATE
                                                                        : quotient[RATE_W-1:0];
                  SCALE_X10:  rate_in = (quotient >= DATA_W'(10)) ? FULL_RATE : times10;
                  default:    rate_in = (quotient != '0) ? FULL_RATE : '0;
               endcase
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register can take the transfer
            if (out_free) begin
               win_cmd.update = 1'b1;
               rsp_tvalid_in  = 1'b1;
               rsp_tdata_in   = {5'b0,
                                 normal_ff && win_stat.switched,
                                 win_stat.channel ^ win_stat.switched,
                                 win_stat.switched,
                                 flag,
                                 rate_ff};
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      normal_ff   <= normal_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      scale_ff    <= scale_in;
      a_wins_ff   <= a_wins_in;
      below_ff    <= below_in;
      den_zero_ff <= den_zero_in;
      rate_ff     <= rate_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   cid_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numerator),
      .divisor  (den_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   cid_win_tracker u_win_tracker (
      .clock      (clock),
      .reset      (reset),
      .count_gate (gate_ff),
      .cmd        (win_cmd),
      .stat       (win_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
